[rtl/r250_pkg.sv]
// r250_pkg: shared constants and controller/datapath command and status types
// for the R250 random word generator. No dependencies.
package r250_pkg;

  localparam int RING_DEPTH = 250;
  localparam int WORD_W     = 31;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int MULT_W     = 15;
  localparam int PROD_W     = WORD_W + MULT_W;
  localparam int SHORT_LAG  = 103;
  localparam int TAP_OFFSET = RING_DEPTH - SHORT_LAG;

  localparam logic [MULT_W-1:0] LCG_MULT  = MULT_W'(16807);
  localparam logic [WORD_W-1:0] LCG_MOD   = WORD_W'(2147483647);
  localparam logic [WORD_W-1:0] SEED_INIT = WORD_W'(1);

  // Commands from controller to datapath
  typedef struct packed {
    logic seed_load;   // load LCG from seed, clear fill count
    logic lcg_mul;     // register state times multiplier
    logic lcg_fold;    // reduce product, write fill word, advance fill count
    logic ring_read;   // read oldest and tap words
    logic word_emit;   // combine, write back, load output register
  } r250_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ring_filled;
    logic fill_last;
    logic out_free;
  } r250_status_t;

endpackage

[rtl/r250_if.sv]
// r250_if: valid/ready channel interfaces for request beats and word beats.
// Depends on r250_pkg for the word width.
interface r250_req_if;
  logic valid;
  logic ready;
  logic request;
  modport source (output valid, output request, input ready);
  modport sink (input valid, input request, output ready);
endinterface

interface r250_word_if;
  logic                        valid;
  logic                        ready;
  logic [r250_pkg::WORD_W-1:0] random_word;
  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

[rtl/r250_ram.sv]
// r250_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
module r250_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/r250_ctrl.sv]
// r250_ctrl: sequencer for ring fill and word generation.
// Depends on r250_pkg and r250_if.
module r250_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  r250_req_if.sink               req,
  input  r250_pkg::r250_status_t status,
  output r250_pkg::r250_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEED = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_GEN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req.ready  = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (req.valid && req.request) begin
          state_next = status.ring_filled ? ST_READ : ST_SEED;
        end
      end
      ST_SEED: begin
        cmd.seed_load = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.lcg_mul = 1'b1;
        state_next  = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.lcg_fold = 1'b1;
        state_next   = status.fill_last ? ST_READ : ST_MUL;
      end
      ST_READ: begin
        cmd.ring_read = 1'b1;
        state_next    = ST_GEN;
      end
      ST_GEN: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.word_emit = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_gen_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN && !status.out_free) |=> (state == ST_GEN))
    else $error("generate step left while output register was busy");
  a_fill_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEED) |-> !status.ring_filled)
    else $error("ring fill restarted after completion");
`endif

endmodule

[rtl/r250_dp.sv]
// r250_dp: seed register, LCG, lag ring pointers, ring memory and output register.
// Depends on r250_pkg, r250_if and r250_ram.
module r250_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [r250_pkg::WORD_W-1:0] cfg_data,
  input  r250_pkg::r250_cmd_t         cmd,
  output r250_pkg::r250_status_t      status,
  r250_word_if.source                 word
);

  logic [r250_pkg::WORD_W-1:0] seed;
  logic [r250_pkg::WORD_W-1:0] lcg_state;
  logic [r250_pkg::PROD_W-1:0] prod;
  logic [r250_pkg::PTR_W-1:0]  fill_count;
  logic [r250_pkg::PTR_W-1:0]  pointer;
  logic                        ring_filled;
  logic                        out_valid;
  logic [r250_pkg::WORD_W-1:0] out_word;

  logic [r250_pkg::WORD_W:0]   fold_sum;
  logic [r250_pkg::WORD_W-1:0] lcg_next;
  logic [r250_pkg::PTR_W:0]    tap_sum;
  logic [r250_pkg::PTR_W-1:0]  tap_addr;
  logic [r250_pkg::PTR_W-1:0]  waddr;
  logic [r250_pkg::WORD_W-1:0] wdata;
  logic [r250_pkg::WORD_W-1:0] rd_old;
  logic [r250_pkg::WORD_W-1:0] rd_tap;
  logic [r250_pkg::WORD_W-1:0] gen_word;
  logic                        fill_last;
  logic                        ptr_last;

  // Mersenne fold: hi + lo, then one conditional subtract of the modulus
  assign fold_sum = {1'b0, prod[r250_pkg::WORD_W-1:0]}
                  + (r250_pkg::WORD_W + 1)'(prod[r250_pkg::PROD_W-1:r250_pkg::WORD_W]);
  assign lcg_next = (fold_sum >= {1'b0, r250_pkg::LCG_MOD})
                  ? r250_pkg::WORD_W'(fold_sum - {1'b0, r250_pkg::LCG_MOD})
                  : fold_sum[r250_pkg::WORD_W-1:0];

  assign tap_sum  = {1'b0, pointer} + (r250_pkg::PTR_W + 1)'(r250_pkg::TAP_OFFSET);
  assign tap_addr = (tap_sum >= (r250_pkg::PTR_W + 1)'(r250_pkg::RING_DEPTH))
                  ? r250_pkg::PTR_W'(tap_sum - (r250_pkg::PTR_W + 1)'(r250_pkg::RING_DEPTH))
                  : tap_sum[r250_pkg::PTR_W-1:0];

  assign gen_word  = rd_old ^ rd_tap;
  assign fill_last = (fill_count == r250_pkg::PTR_W'(r250_pkg::RING_DEPTH - 1));
  assign ptr_last  = (pointer == r250_pkg::PTR_W'(r250_pkg::RING_DEPTH - 1));
  assign waddr     = cmd.lcg_fold ? fill_count : pointer;
  assign wdata     = cmd.lcg_fold ? lcg_next : gen_word;

  assign status.ring_filled = ring_filled;
  assign status.fill_last   = fill_last;
  assign status.out_free    = !out_valid || word.ready;

  assign word.valid       = out_valid;
  assign word.random_word = out_word;

  r250_ram #(
    .DEPTH (r250_pkg::RING_DEPTH),
    .WIDTH (r250_pkg::WORD_W)
  ) u_ring (
    .clk     (clk),
    .we      (cmd.lcg_fold || cmd.word_emit),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (cmd.ring_read),
    .raddr_a (pointer),
    .raddr_b (tap_addr),
    .rdata_a (rd_old),
    .rdata_b (rd_tap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed        <= r250_pkg::SEED_INIT;
      lcg_state   <= '0;
      fill_count  <= '0;
      pointer     <= '0;
      ring_filled <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_data;
      end
      if (cmd.seed_load) begin
        lcg_state  <= seed;
        fill_count <= '0;
      end else if (cmd.lcg_fold) begin
        lcg_state  <= lcg_next;
        fill_count <= fill_count + r250_pkg::PTR_W'(1);
        if (fill_last) begin
          ring_filled <= 1'b1;
          pointer     <= '0;
        end
      end
      if (cmd.word_emit) begin
        pointer   <= ptr_last ? '0 : pointer + r250_pkg::PTR_W'(1);
        out_valid <= 1'b1;
      end else if (word.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lcg_mul) begin
      prod <= r250_pkg::PROD_W'(lcg_state) * r250_pkg::PROD_W'(r250_pkg::LCG_MULT);
    end
    if (cmd.word_emit) begin
      out_word <= gen_word;
    end
  end

`ifndef ASSERT_OFF
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    pointer < r250_pkg::PTR_W'(r250_pkg::RING_DEPTH))
    else $error("ring pointer out of range");
  a_emit_filled: assert property (@(posedge clk) disable iff (rst)
    cmd.word_emit |-> ring_filled)
    else $error("word generated before the ring was filled");
  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.lcg_fold && fill_last) |=> (ring_filled && pointer == '0))
    else $error("fill completion did not arm the ring");
`endif

endmodule

[rtl/r250_random_generator.sv]
// r250_random_generator: top level of the R250 GFSR random word generator.
// Depends on r250_pkg, r250_if, r250_ctrl and r250_dp.
//
// Usage:
//   req  : request beats (valid/ready). A beat with request high asks for the
//          next 31-bit word; a beat with request low is taken and dropped.
//   word : result beats (valid/ready), random_word is an unsigned fraction
//          with 31 fractional bits, word[n] = word[n-250] ^ word[n-103].
//   cfg_we / cfg_data : write the LCG seed (reset value 1) while idle.
// Sequencing:
//   Once the ring is filled, a request beat is taken in idle, then the
//   read step issues the two registered ring reads and the generate step
//   combines, writes back and loads the output register; the controller
//   returns to idle before it takes the next beat, so one request is in
//   flight at a time. The first request after reset first fills the
//   250-word ring from the Park-Miller LCG: a seed step, then per word a
//   registered multiply, then the Mersenne fold and ring write, one word
//   at a time through the single ring write port and the one LCG unit.
// Reset: rst is synchronous, active high; it clears the pointers, the
//   filled flag and the output valid flag. The ring itself is not cleared.
// Stall: the output register holds the word while word.ready is low; the
//   next request beat is still taken and its word waits in the generate step.
module r250_random_generator (
  input  logic                        clk,
  input  logic                        rst,
  r250_req_if.sink                    req,
  r250_word_if.source                 word,
  input  logic                        cfg_we,
  input  logic [r250_pkg::WORD_W-1:0] cfg_data
);

  r250_pkg::r250_cmd_t    cmd;
  r250_pkg::r250_status_t status;

  // sequence the fill and each generate step
  r250_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .status (status),
    .cmd    (cmd)
  );

  // seed, LCG, ring memory, pointers and output register
  r250_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .word     (word)
  );

endmodule

[sim/r250_word_checker.sv]
// r250_word_checker: watches the request, word and seed ports of the R250
// generator, predicts every word and compares each word beat in order.
// Depends on r250_pkg and the channel interfaces in r250_if.
module r250_word_checker (
  input  logic                        clk,
  input  logic                        rst,
  r250_req_if                         req,
  r250_word_if                        word,
  input  logic                        cfg_we,
  input  logic [r250_pkg::WORD_W-1:0] cfg_data,
  output int                          mismatch_count,
  output int                          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [r250_pkg::WORD_W-1:0] seed_q;
  logic [r250_pkg::WORD_W-1:0] ring_q [r250_pkg::RING_DEPTH];
  int unsigned                 oldest_q;
  bit                          ring_loaded;
  logic [r250_pkg::WORD_W-1:0] expected_words [$];
  int                          fails = 0;

  // One Park-Miller step: (s * 16807) mod (2^31 - 1), done in 64 bits.
  function automatic logic [r250_pkg::WORD_W-1:0] park_miller_step(
    input logic [r250_pkg::WORD_W-1:0] s
  );
    logic [63:0] prod;
    prod = 64'(s) * 64'(r250_pkg::LCG_MULT);
    return r250_pkg::WORD_W'(prod % 64'(r250_pkg::LCG_MOD));
  endfunction

  task automatic load_ring();
    logic [r250_pkg::WORD_W-1:0] s;
    s = seed_q;
    for (int k = 0; k < r250_pkg::RING_DEPTH; k++) begin
      s = park_miller_step(s);
      ring_q[k] = s;
    end
    oldest_q    = 0;
    ring_loaded = 1'b1;
  endtask

  // w[n] = w[n-250] ^ w[n-103]; the new word overwrites the oldest slot.
  function automatic logic [r250_pkg::WORD_W-1:0] advance_ring();
    int unsigned                 tap;
    logic [r250_pkg::WORD_W-1:0] w;
    tap = (oldest_q + r250_pkg::TAP_OFFSET) % r250_pkg::RING_DEPTH;
    w = ring_q[oldest_q] ^ ring_q[tap];
    ring_q[oldest_q] = w;
    oldest_q = (oldest_q + 1) % r250_pkg::RING_DEPTH;
    return w;
  endfunction

  always @(posedge clk) begin : track
    logic [r250_pkg::WORD_W-1:0] want;
    if (rst) begin
      seed_q      = r250_pkg::SEED_INIT;
      oldest_q    = 0;
      ring_loaded = 1'b0;
      expected_words.delete();
    end else begin
      // Compare first: a word beat never belongs to a request taken this edge.
      if (word.valid && word.ready) begin
        if (expected_words.size() == 0) begin
          $error("random_word: unexpected beat, expected none, actual %h", word.random_word);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (word.random_word !== want) begin
            $error("random_word: expected %h, actual %h", want, word.random_word);
            fails++;
          end
        end
      end
      // The seed only matters at the fill; later writes are held but unused.
      if (cfg_we) seed_q = cfg_data;
      if (req.valid && req.ready && req.request === 1'b1) begin
        if (!ring_loaded) load_ring();
        expected_words.push_back(advance_ring());
      end
    end
    mismatch_count <= fails;
    words_pending  <= expected_words.size();
  end

endmodule

[sim/r250_random_generator_tb.sv]
// r250_random_generator_tb: drives request beats and seed writes into the
// R250 generator under random idling and gives the verdict.
// Depends on r250_pkg, r250_if, r250_random_generator and r250_word_checker.
module r250_random_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [r250_pkg::WORD_W-1:0] cfg_data;
  int                          mismatch_count;
  int                          words_pending;

  // Receiver controls: idle percentage and a one-shot long hold-off request.
  int sink_idle_pct = 0;
  int hold_off_ask  = 0;
  int hold_off_left = 0;

  r250_req_if  req_ch ();
  r250_word_if word_ch ();

  r250_random_generator i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .word    (word_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  r250_word_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .word          (word_ch),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up after a time far beyond the slowest correct run
  // (the ring fill plus ~1400 beats).
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: drive ready at every falling edge. A hold-off request drops
  // ready for that many cycles, counted here, whatever the idle setting.
  initial begin
    word_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        word_ch.ready <= 1'b0;
        hold_off_left--;
      end else if (hold_off_ask > 0) begin
        word_ch.ready <= 1'b0;
        hold_off_left = hold_off_ask - 1;
        hold_off_ask  = 0;
      end else begin
        word_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Offer one request beat and hold it until it is taken. Enter and leave
  // at a falling edge; valid is assigned once per step so a back-to-back
  // beat keeps valid high without a glitch.
  task automatic send_beat(input logic want, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid   <= 1'b0;
      req_ch.request <= 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.request <= want;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Write the seed register for one cycle. Enter and leave at a falling edge.
  task automatic write_seed(input logic [r250_pkg::WORD_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted word, then let the block settle
  // in idle before touching the seed.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One random phase: mostly word requests, about one beat in ten a
  // request-low beat that the block drops (not counted toward the total).
  task automatic run_phase(input int src_pct, input int snk_pct, input int words,
                           input bit long_hold);
    int sent;
    sent = 0;
    sink_idle_pct = snk_pct;
    if (long_hold) hold_off_ask = 150;
    while (sent < words) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(1'b0, src_pct);
      end else begin
        send_beat(1'b1, src_pct);
        sent++;
      end
    end
    drain();
  endtask

  initial begin : stimulus
    logic [r250_pkg::WORD_W-1:0] fill_seed;
    int                          pick;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.request = 1'b0;

    // Hold reset, then release it once for the whole run.
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Seed before the fill: zero and all ones first (every bit both ways),
    // then the one that counts. Now and then the fill seed is itself an
    // extreme; zero and the modulus give an all-zero ring.
    write_seed('0);
    write_seed('1);
    pick = $urandom_range(0, 11);
    unique case (pick)
      0:       fill_seed = '0;
      1:       fill_seed = '1;
      2:       fill_seed = r250_pkg::WORD_W'(1);
      3:       fill_seed = r250_pkg::LCG_MOD - r250_pkg::WORD_W'(1);
      default: fill_seed = r250_pkg::WORD_W'($urandom_range(1, 32'd2147483646));
    endcase
    write_seed(fill_seed);

    // Directed beats: a dropped request-low beat before the fill, the first
    // request that triggers the fill, a burst right behind it, and request-low
    // beats mixed into the stream.
    send_beat(1'b0, 0);
    send_beat(1'b1, 0);
    send_beat(1'b0, 0);
    repeat (12) send_beat(1'b1, 0);
    send_beat(1'b0, 0);
    send_beat(1'b1, 0);
    send_beat(1'b0, 0);
    repeat (4) send_beat(1'b1, 0);
    drain();

    // Seed writes after the fill must not change the sequence.
    write_seed('0);
    write_seed('1);

    // Sender idles a third of the time, receiver three quarters.
    run_phase(34, 74, 420, 1'b0);
    write_seed(r250_pkg::WORD_W'($urandom_range(1, 32'd2147483646)));

    // Swap the idling.
    run_phase(74, 34, 420, 1'b0);
    write_seed(r250_pkg::LCG_MOD - r250_pkg::WORD_W'(1));

    // No idling; start with a long receiver hold-off so the block backs up
    // and stalls the request channel while beats keep coming.
    run_phase(0, 0, 420, 1'b1);

    // Allow late or stray word beats to show up before the verdict.
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
